### hw/rtl/rlm_pkg.sv
package rlm_pkg;

   localparam int SAMPLE_W = 16;
   localparam int SQ_W     = 31;
   localparam int TOTAL_W  = 41;
   localparam int LEN_W    = 13;
   localparam int POS_W    = 12;
   localparam int STEP_W   = 5;
   localparam int PHASE_W  = 4;
   localparam int RMS_W    = 16;
   localparam int LEVEL_W  = 15;
   localparam int ROOT_W   = (TOTAL_W + 1) / 2;
   localparam int RAD_W    = 2 * ROOT_W;

   localparam logic [LEN_W-1:0] MAX_FRAME    = LEN_W'(4096);
   localparam logic [LEN_W-1:0] RESET_LENGTH = LEN_W'(256);
   localparam logic [LEN_W-1:0] STEP_LIMIT   = LEN_W'(1024);

   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   typedef struct packed {
      logic [TOTAL_W-1:0] total;
      logic [LEN_W-1:0]   count;
   } frame_type;

   typedef struct packed {
      logic      push;
      frame_type frame;
   } q_wr_type;

   typedef struct packed {
      logic      empty;
      frame_type frame;
   } q_rd_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_DIV,
      BK_SQRT,
      BK_EMIT
   } bk_state_type;

endpackage

### hw/rtl/rlm_queue.sv
module rlm_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  rlm_pkg::q_wr_type        wr,
   input  logic                     pop,
   output rlm_pkg::q_rd_type        rd,
   output logic [rlm_pkg::QCNT_W-1:0] level
);

   localparam int QCNT_W = rlm_pkg::QCNT_W;

   rlm_pkg::frame_type               mem_ff [rlm_pkg::QDEPTH];
   logic [rlm_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [rlm_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [rlm_pkg::QCNT_W-1:0]       cnt_ff, cnt_in;
   logic                             do_pop;

   always_comb begin
      do_pop    = pop && (cnt_ff != '0);
      wr_ptr_in = wr.push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff + QCNT_W'(wr.push) - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.push) begin
         mem_ff[wr_ptr_ff] <= wr.frame;
      end
   end

   assign rd.empty = (cnt_ff == '0);
   assign rd.frame = mem_ff[rd_ptr_ff];
   assign level    = cnt_ff;

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      wr.push && !do_pop |-> cnt_ff != QCNT_W'(rlm_pkg::QDEPTH))
      else $error("frame queue overflow");

endmodule

### hw/rtl/rlm_front.sv
module rlm_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   output logic                                full,
   input  logic signed [rlm_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                                csr_write_en,
   input  logic [rlm_pkg::LEN_W-1:0]           csr_frame_length,
   output rlm_pkg::q_wr_type                   q_wr,
   input  logic [rlm_pkg::QCNT_W-1:0]          q_level
);

   localparam int LEN_W   = rlm_pkg::LEN_W;
   localparam int POS_W   = rlm_pkg::POS_W;
   localparam int STEP_W  = rlm_pkg::STEP_W;
   localparam int PHASE_W = rlm_pkg::PHASE_W;
   localparam int SQ_W    = rlm_pkg::SQ_W;
   localparam int TOTAL_W = rlm_pkg::TOTAL_W;
   localparam int IT_W    = $clog2(LEN_W);
   localparam int LVL_W   = rlm_pkg::QCNT_W + 1;

   logic [LEN_W-1:0]   frame_length_ff, frame_length_in;
   logic [POS_W-1:0]   position_ff, position_in;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [LEN_W-1:0]   count_ff, count_in;

   logic               ld_ff, ld_in;
   logic               run_ff, run_in;
   logic [IT_W-1:0]    it_ff, it_in;
   logic [LEN_W-1:0]   pos_sh_ff, pos_sh_in;
   logic [LEN_W-1:0]   cnt_sh_ff, cnt_sh_in;
   logic [PHASE_W-1:0] pos_rem_ff, pos_rem_in;
   logic [PHASE_W-1:0] cnt_rem_ff, cnt_rem_in;

   logic               s1_valid_ff, s1_valid_in;
   logic               s1_take_ff, s1_take_in;
   logic               s1_last_ff, s1_last_in;
   logic [LEN_W-1:0]   s1_count_ff;
   logic signed [rlm_pkg::SAMPLE_W-1:0] s1_sample_ff;

   logic               s2_valid_ff;
   logic               s2_take_ff;
   logic               s2_last_ff;
   logic [LEN_W-1:0]   s2_count_ff;
   logic [SQ_W-1:0]    s2_sq_ff;
   logic signed [2*rlm_pkg::SAMPLE_W-1:0] product;

   logic [TOTAL_W-1:0] acc_ff, acc_in, acc_sum;

   logic [LEN_W-1:0]   len;
   logic [STEP_W-1:0]  step;
   logic               cfg_busy;
   logic [LVL_W-1:0]   pending;
   logic               accept;
   logic               last;
   logic [STEP_W-1:0]  phase_inc;
   logic [STEP_W-1:0]  pos_rsh, cnt_rsh;
   logic               pos_ge, cnt_ge;
   logic [STEP_W-1:0]  pos_diff, cnt_diff;

   always_comb begin
      if (frame_length_ff == '0) begin
         len = LEN_W'(1);
      end else if (frame_length_ff > rlm_pkg::MAX_FRAME) begin
         len = rlm_pkg::MAX_FRAME;
      end else begin
         len = frame_length_ff;
      end
      step = (len > rlm_pkg::STEP_LIMIT) ? len[LEN_W-1:LEN_W-STEP_W] : STEP_W'(1);
   end

   always_comb begin
      cfg_busy = ld_ff || run_ff;
      pending  = LVL_W'(q_level) + LVL_W'(s1_valid_ff && s1_last_ff)
               + LVL_W'(s2_valid_ff && s2_last_ff);
      full     = cfg_busy || (pending >= LVL_W'(rlm_pkg::QDEPTH));
      accept   = push && !full;
      last     = ({1'b0, position_ff} + LEN_W'(1)) >= len;
      phase_inc = {1'b0, phase_ff} + STEP_W'(1);

      frame_length_in = csr_write_en ? csr_frame_length : frame_length_ff;
      position_in     = position_ff;
      phase_in        = phase_ff;
      count_in        = count_ff;

      s1_valid_in = accept;
      s1_take_in  = (phase_ff == '0);
      s1_last_in  = last;

      if (accept) begin
         if (last) begin
            position_in = '0;
            phase_in    = '0;
         end else begin
            position_in = position_ff + POS_W'(1);
            phase_in    = (phase_inc == step) ? '0 : phase_inc[PHASE_W-1:0];
         end
      end

      // long division of position and of (len + step - 1) by step, one bit a cycle
      pos_rsh  = {pos_rem_ff, pos_sh_ff[LEN_W-1]};
      cnt_rsh  = {cnt_rem_ff, cnt_sh_ff[LEN_W-1]};
      pos_ge   = pos_rsh >= step;
      cnt_ge   = cnt_rsh >= step;
      pos_diff = pos_rsh - step;
      cnt_diff = cnt_rsh - step;

      ld_in      = csr_write_en;
      run_in     = run_ff;
      it_in      = it_ff;
      pos_sh_in  = pos_sh_ff;
      cnt_sh_in  = cnt_sh_ff;
      pos_rem_in = pos_rem_ff;
      cnt_rem_in = cnt_rem_ff;

      if (csr_write_en) begin
         run_in = 1'b0;
      end else if (ld_ff) begin
         run_in     = 1'b1;
         it_in      = '0;
         pos_sh_in  = {1'b0, position_ff};
         cnt_sh_in  = len + LEN_W'(step) - LEN_W'(1);
         pos_rem_in = '0;
         cnt_rem_in = '0;
      end else if (run_ff) begin
         it_in      = it_ff + IT_W'(1);
         pos_sh_in  = {pos_sh_ff[LEN_W-2:0], pos_ge};
         cnt_sh_in  = {cnt_sh_ff[LEN_W-2:0], cnt_ge};
         pos_rem_in = pos_ge ? pos_diff[PHASE_W-1:0] : pos_rsh[PHASE_W-1:0];
         cnt_rem_in = cnt_ge ? cnt_diff[PHASE_W-1:0] : cnt_rsh[PHASE_W-1:0];
         if (it_ff == IT_W'(LEN_W - 1)) begin
            run_in   = 1'b0;
            phase_in = pos_rem_in;
            count_in = cnt_sh_in;
         end
      end

      acc_sum = acc_ff + (s2_take_ff ? TOTAL_W'(s2_sq_ff) : '0);
      acc_in  = acc_ff;
      if (s2_valid_ff) begin
         acc_in = s2_last_ff ? '0 : acc_sum;
      end

      product = s1_sample_ff * s1_sample_ff;
   end

   assign q_wr.push        = s2_valid_ff && s2_last_ff;
   assign q_wr.frame.total = acc_sum;
   assign q_wr.frame.count = s2_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_length_ff <= rlm_pkg::RESET_LENGTH;
         position_ff     <= '0;
         phase_ff        <= '0;
         count_ff        <= rlm_pkg::RESET_LENGTH;
         ld_ff           <= 1'b0;
         run_ff          <= 1'b0;
         it_ff           <= '0;
         s1_valid_ff     <= 1'b0;
         s1_take_ff      <= 1'b0;
         s1_last_ff      <= 1'b0;
         s2_valid_ff     <= 1'b0;
         s2_take_ff      <= 1'b0;
         s2_last_ff      <= 1'b0;
         acc_ff          <= '0;
      end else begin
         frame_length_ff <= frame_length_in;
         position_ff     <= position_in;
         phase_ff        <= phase_in;
         count_ff        <= count_in;
         ld_ff           <= ld_in;
         run_ff          <= run_in;
         it_ff           <= it_in;
         s1_valid_ff     <= s1_valid_in;
         s1_take_ff      <= s1_take_in;
         s1_last_ff      <= s1_last_in;
         s2_valid_ff     <= s1_valid_ff;
         s2_take_ff      <= s1_take_ff;
         s2_last_ff      <= s1_last_ff;
         acc_ff          <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_sh_ff    <= pos_sh_in;
      cnt_sh_ff    <= cnt_sh_in;
      pos_rem_ff   <= pos_rem_in;
      cnt_rem_ff   <= cnt_rem_in;
      s1_sample_ff <= req_sample;
      s1_count_ff  <= count_ff;
      s2_sq_ff     <= product[SQ_W-1:0];
      s2_count_ff  <= s1_count_ff;
   end

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |-> !cfg_busy)
      else $error("sample transfer during length update");

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      !cfg_busy |-> {1'b0, phase_ff} < step)
      else $error("phase out of range");

   a_queue_room: assert property (@(posedge clock) disable iff (reset)
      q_wr.push |-> q_level < rlm_pkg::QCNT_W'(rlm_pkg::QDEPTH))
      else $error("frame pushed into full queue");

   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      !cfg_busy |-> count_ff != '0)
      else $error("zero sample count");

endmodule

### hw/rtl/rlm_back.sv
module rlm_back (
   input  logic                              clock,
   input  logic                              reset,
   input  rlm_pkg::q_rd_type                 q_rd,
   output logic                              q_pop,
   output logic                              empty,
   input  logic                              pop,
   output logic [rlm_pkg::RMS_W-1:0]         rsp_rms_out,
   output logic [rlm_pkg::LEVEL_W-1:0]       rsp_level_out
);

   localparam int TOTAL_W = rlm_pkg::TOTAL_W;
   localparam int LEN_W   = rlm_pkg::LEN_W;
   localparam int ROOT_W  = rlm_pkg::ROOT_W;
   localparam int RAD_W   = rlm_pkg::RAD_W;
   localparam int SREM_W  = ROOT_W + 2;
   localparam int TRY_W   = ROOT_W + 4;
   localparam int IT_W    = $clog2(TOTAL_W);
   localparam int SCL_W   = ROOT_W + 5;
   localparam int LEVEL_W = rlm_pkg::LEVEL_W;

   rlm_pkg::bk_state_type state_ff, state_in;

   logic [IT_W-1:0]    it_ff, it_in;
   logic [TOTAL_W-1:0] quo_ff, quo_in;
   logic [LEN_W-1:0]   drem_ff, drem_in;
   logic [LEN_W-1:0]   dvsr_ff, dvsr_in;
   logic [RAD_W-1:0]   rad_ff, rad_in;
   logic [ROOT_W-1:0]  root_ff, root_in;
   logic [SREM_W-1:0]  srem_ff, srem_in;
   logic [LEVEL_W-1:0] meter_ff, meter_in;
   logic               out_valid_ff, out_valid_in;
   logic [rlm_pkg::RMS_W-1:0] out_rms_ff, out_rms_in;
   logic [LEVEL_W-1:0] out_level_ff, out_level_in;

   logic [LEN_W:0]     d_rsh, d_diff;
   logic               d_ge;
   logic [TRY_W-1:0]   s_rsh, s_try, s_diff;
   logic               s_ge;
   logic [SCL_W-1:0]   scaled;
   logic [SCL_W:0]     lvl_sum;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rlm_pkg::BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      d_rsh  = {drem_ff, quo_ff[TOTAL_W-1]};
      d_ge   = d_rsh >= {1'b0, dvsr_ff};
      d_diff = d_rsh - {1'b0, dvsr_ff};

      s_rsh  = {srem_ff, rad_ff[RAD_W-1:RAD_W-2]};
      s_try  = {2'b00, root_ff, 2'b01};
      s_ge   = s_rsh >= s_try;
      s_diff = s_rsh - s_try;

      scaled  = (SCL_W'(root_ff) * SCL_W'(25)) >> 5;
      lvl_sum = (SCL_W + 1)'(meter_ff) + (SCL_W + 1)'(scaled);

      state_in     = state_ff;
      q_pop        = 1'b0;
      it_in        = it_ff;
      quo_in       = quo_ff;
      drem_in      = drem_ff;
      dvsr_in      = dvsr_ff;
      rad_in       = rad_ff;
      root_in      = root_ff;
      srem_in      = srem_ff;
      meter_in     = meter_ff;
      out_valid_in = out_valid_ff && !pop;
      out_rms_in   = out_rms_ff;
      out_level_in = out_level_ff;

      case (state_ff)
         rlm_pkg::BK_IDLE: begin
            if (!q_rd.empty) begin
               q_pop    = 1'b1;
               quo_in   = q_rd.frame.total;
               dvsr_in  = q_rd.frame.count;
               drem_in  = '0;
               it_in    = '0;
               state_in = rlm_pkg::BK_DIV;
            end
         end
         rlm_pkg::BK_DIV: begin
            quo_in  = {quo_ff[TOTAL_W-2:0], d_ge};
            drem_in = d_ge ? d_diff[LEN_W-1:0] : d_rsh[LEN_W-1:0];
            it_in   = it_ff + IT_W'(1);
            if (it_ff == IT_W'(TOTAL_W - 1)) begin
               rad_in   = RAD_W'(quo_in);
               root_in  = '0;
               srem_in  = '0;
               it_in    = '0;
               state_in = rlm_pkg::BK_SQRT;
            end
         end
         rlm_pkg::BK_SQRT: begin
            rad_in  = {rad_ff[RAD_W-3:0], 2'b00};
            root_in = {root_ff[ROOT_W-2:0], s_ge};
            srem_in = s_ge ? s_diff[SREM_W-1:0] : s_rsh[SREM_W-1:0];
            it_in   = it_ff + IT_W'(1);
            if (it_ff == IT_W'(ROOT_W - 1)) begin
               state_in = rlm_pkg::BK_EMIT;
            end
         end
         rlm_pkg::BK_EMIT: begin
            if (!out_valid_ff) begin
               meter_in     = lvl_sum[LEVEL_W:1];
               out_level_in = lvl_sum[LEVEL_W:1];
               out_rms_in   = root_ff[rlm_pkg::RMS_W-1:0];
               out_valid_in = 1'b1;
               state_in     = rlm_pkg::BK_IDLE;
            end
         end
         default: begin
            state_in = rlm_pkg::BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         meter_ff     <= '0;
         out_valid_ff <= 1'b0;
         it_ff        <= '0;
      end else begin
         meter_ff     <= meter_in;
         out_valid_ff <= out_valid_in;
         it_ff        <= it_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff       <= quo_in;
      drem_ff      <= drem_in;
      dvsr_ff      <= dvsr_in;
      rad_ff       <= rad_in;
      root_ff      <= root_in;
      srem_ff      <= srem_in;
      out_rms_ff   <= out_rms_in;
      out_level_ff <= out_level_in;
   end

   assign empty         = !out_valid_ff;
   assign rsp_rms_out   = out_rms_ff;
   assign rsp_level_out = out_level_ff;

   a_divisor_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == rlm_pkg::BK_DIV |-> dvsr_ff != '0)
      else $error("divide by zero count");

   a_pop_has_entry: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_rd.empty)
      else $error("pop from empty frame queue");

   a_emit_loads: assert property (@(posedge clock) disable iff (reset)
      state_ff == rlm_pkg::BK_EMIT && !out_valid_ff |=> out_valid_ff)
      else $error("result not loaded");

endmodule

### hw/rtl/rms_level_meter.sv
// Channel   Ports                                Transfer
// input     push, full, req_sample               push && !full
// result    empty, pop, rsp_rms_out, rsp_level_out  pop && !empty
// csr       csr_write_en, csr_frame_length       csr_write_en
//
// Samples enter at one per cycle while full is low, through a square and
// accumulate pipe. Each finished frame waits in a 4-entry queue; the back end
// runs a restoring divide and a bit-pair square root on one frame at a time.
// A length write holds full high while the step phase and the sample count
// are recomputed. Reset sets the length to 256 and the level to 0.
// full also rises while frame ends in flight would overfill the queue.
module rms_level_meter (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   output logic                                full,
   input  logic signed [rlm_pkg::SAMPLE_W-1:0] req_sample,
   output logic                                empty,
   input  logic                                pop,
   output logic [rlm_pkg::RMS_W-1:0]           rsp_rms_out,
   output logic [rlm_pkg::LEVEL_W-1:0]         rsp_level_out,
   input  logic                                csr_write_en,
   input  logic [rlm_pkg::LEN_W-1:0]           csr_frame_length
);

   rlm_pkg::q_wr_type          q_wr;
   rlm_pkg::q_rd_type          q_rd;
   logic                       q_pop;
   logic [rlm_pkg::QCNT_W-1:0] q_level;

   rlm_front u_front (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_sample       (req_sample),
      .csr_write_en     (csr_write_en),
      .csr_frame_length (csr_frame_length),
      .q_wr             (q_wr),
      .q_level          (q_level)
   );

   rlm_queue u_queue (
      .clock (clock),
      .reset (reset),
      .wr    (q_wr),
      .pop   (q_pop),
      .rd    (q_rd),
      .level (q_level)
   );

   rlm_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_rd          (q_rd),
      .q_pop         (q_pop),
      .empty         (empty),
      .pop           (pop),
      .rsp_rms_out   (rsp_rms_out),
      .rsp_level_out (rsp_level_out)
   );

endmodule

### dv/meter_checker.sv
`timescale 1ns / 100ps

module meter_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   input  logic                                full,
   input  logic signed [rlm_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                                empty,
   input  logic                                pop,
   input  logic [rlm_pkg::RMS_W-1:0]           rsp_rms_out,
   input  logic [rlm_pkg::LEVEL_W-1:0]         rsp_level_out,
   input  logic                                csr_write_en,
   input  logic [rlm_pkg::LEN_W-1:0]           csr_frame_length,
   output int                                  fail_count,
   output int                                  pending_count,
   output int                                  reading_count
);

   typedef struct packed {
      logic [rlm_pkg::RMS_W-1:0]   rms;
      logic [rlm_pkg::LEVEL_W-1:0] level;
   } reading_type;

   reading_type                   expected_readings[$];
   logic [rlm_pkg::LEN_W-1:0]     frame_len;
   logic [rlm_pkg::TOTAL_W-1:0]   square_sum;
   int unsigned                   frame_pos;
   logic [rlm_pkg::LEVEL_W-1:0]   level_acc;
   int                            failures;

   function automatic longint unsigned floor_root(input longint unsigned v);
      longint unsigned root;
      longint unsigned trial;
      root = 0;
      for (int b = 20; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= v) root = trial;
      end
      return root;
   endfunction

   task automatic meter_sample(input logic signed [rlm_pkg::SAMPLE_W-1:0] s);
      int unsigned     span;
      int unsigned     stride;
      int unsigned     count;
      longint          sq;
      longint unsigned mean;
      longint unsigned rms;
      longint unsigned scaled;
      reading_type     r;
      if (frame_len == 0) span = 1;
      else if (frame_len > rlm_pkg::MAX_FRAME) span = rlm_pkg::MAX_FRAME;
      else span = frame_len;
      stride = (span > rlm_pkg::STEP_LIMIT) ? span / 256 : 1;
      if (frame_pos % stride == 0) begin
         sq = longint'(s) * longint'(s);
         square_sum = rlm_pkg::TOTAL_W'(square_sum + sq);
      end
      if (frame_pos + 1 >= span) begin
         count = (span + stride - 1) / stride;
         mean = square_sum / count;
         rms = floor_root(mean);
         scaled = rms * 25 / 32;
         level_acc = rlm_pkg::LEVEL_W'((level_acc + scaled) / 2);
         r.rms = rlm_pkg::RMS_W'(rms);
         r.level = level_acc;
         expected_readings.push_back(r);
         square_sum = '0;
         frame_pos = 0;
      end else begin
         frame_pos++;
      end
   endtask

   always @(posedge clock) begin
      reading_type want;
      if (reset) begin
         frame_len = rlm_pkg::RESET_LENGTH;
         square_sum = '0;
         frame_pos = 0;
         level_acc = '0;
         failures = 0;
         expected_readings.delete();
         reading_count <= 0;
      end else begin
         if (pop && !empty) begin
            reading_count <= reading_count + 1;
            if (expected_readings.size() == 0) begin
               if (failures < 10)
                  $display("%0t: result rms %0d level %0d with none expected",
                           $time, rsp_rms_out, rsp_level_out);
               failures++;
            end else begin
               want = expected_readings.pop_front();
               if (rsp_rms_out !== want.rms || rsp_level_out !== want.level) begin
                  if (failures < 10)
                     $display("%0t: expected rms %0d level %0d, got rms %0d level %0d",
                              $time, want.rms, want.level, rsp_rms_out, rsp_level_out);
                  failures++;
               end
            end
         end
         if (csr_write_en) frame_len = csr_frame_length;
         if (push && !full) meter_sample(req_sample);
      end
      fail_count <= failures;
      pending_count <= expected_readings.size();
   end

endmodule

### dv/tb.sv
`timescale 1ns / 100ps

module tb;

   logic                                clock;
   logic                                reset;
   logic                                push;
   logic                                full;
   logic signed [rlm_pkg::SAMPLE_W-1:0] req_sample;
   logic                                empty;
   logic                                pop;
   logic [rlm_pkg::RMS_W-1:0]           rsp_rms_out;
   logic [rlm_pkg::LEVEL_W-1:0]         rsp_level_out;
   logic                                csr_write_en;
   logic [rlm_pkg::LEN_W-1:0]           csr_frame_length;
   int                                  fail_count;
   int                                  pending_count;
   int                                  reading_count;
   int                                  sent_count;

   bit hold_wanted;
   bit sender_burst;
   bit receiver_burst;

   rms_level_meter dut (.*);
   meter_checker   monitor (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("TB_ERROR");
      $finish;
   end

   function automatic logic [15:0] draw_sample();
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 3))
               0: return 16'h8000;
               1: return 16'h7FFF;
               2: return 16'h0000;
               default: return 16'hFFFF;
            endcase
         end
         1: return $urandom_range(0, 1) ? 16'($urandom_range(0, 255))
                                       : -16'($urandom_range(0, 255));
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_sample(input logic [15:0] s);
      int gap;
      bit taken;
      if ($urandom_range(0, 29) == 0) sender_burst = !sender_burst;
      gap = sender_burst ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         push <= 0;
         repeat (gap) @(posedge clock);
      end
      push <= 1;
      req_sample <= s;
      do begin
         @(negedge clock);
         taken = !full;
         @(posedge clock);
      end while (!taken);
      sent_count++;
   endtask

   // hold until every frame result is out, then let the sample pipe drain
   task automatic wait_drained();
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
      @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic set_frame_length(input logic [rlm_pkg::LEN_W-1:0] v);
      push <= 0;
      wait_drained();
      csr_write_en <= 1;
      csr_frame_length <= v;
      @(posedge clock);
      csr_write_en <= 0;
   endtask

   initial begin
      int gap;
      bit got;
      pop = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 29) == 0) receiver_burst = !receiver_burst;
         if (hold_wanted) begin
            pop <= 0;
            repeat (600) @(posedge clock);
            hold_wanted = 0;
         end
         gap = receiver_burst ? 0 : $urandom_range(0, 3);
         if (gap > 0) begin
            pop <= 0;
            repeat (gap) @(posedge clock);
         end
         pop <= 1;
         do begin
            @(negedge clock);
            got = !empty;
            @(posedge clock);
         end while (!got);
      end
   end

   initial begin
      logic [15:0]               corner_samples[9];
      logic [rlm_pkg::LEN_W-1:0] long_lengths[3];
      logic [rlm_pkg::LEN_W-1:0] len;
      int                        span;
      int                        n;
      int                        phase;
      int                        long_idx;

      corner_samples = '{16'h8000, 16'h7FFF, 16'h0000,
                         16'hFFFF, 16'h0001, 16'h8000,
                         16'h8000, 16'h5555, 16'hAAAA};
      long_lengths = '{13'd4096, 13'd8191, 13'd1025};
      sent_count = 0;
      push = 0;
      req_sample = '0;
      csr_write_en = 0;
      csr_frame_length = '0;
      reset = 1;
      repeat (8) @(posedge clock);
      reset <= 0;

      set_frame_length(13'd1);
      foreach (corner_samples[i]) send_sample(corner_samples[i]);
      set_frame_length(13'd0);
      send_sample(16'h7FFF);
      send_sample(16'hFFFE);
      set_frame_length(13'd3);
      send_sample(16'h8000);
      send_sample(16'h0064);
      send_sample(16'h0007);
      // shrink the length with the frame already past its new end
      set_frame_length(13'd5);
      repeat (3) send_sample(draw_sample());
      set_frame_length(13'd2);
      send_sample(16'h0100);

      // block the result side so the block fills and stalls its input
      set_frame_length(13'd1);
      hold_wanted = 1;
      repeat (40) send_sample(draw_sample());

      phase = 0;
      long_idx = 0;
      while (sent_count < 550 || reading_count < 80) begin
         if (phase % 4 == 2 && long_idx < 3) begin
            len = long_lengths[long_idx];
            long_idx++;
         end else begin
            case ($urandom_range(0, 19))
               0: len = rlm_pkg::LEN_W'($urandom_range(1025, 8191));
               1: len = '0;
               2: len = rlm_pkg::LEN_W'($urandom_range(65, 1024));
               3, 4, 5, 6, 7, 8, 9: len = rlm_pkg::LEN_W'($urandom_range(1, 8));
               default: len = rlm_pkg::LEN_W'($urandom_range(1, 64));
            endcase
         end
         if (len == 0) span = 1;
         else if (len > rlm_pkg::MAX_FRAME) span = rlm_pkg::MAX_FRAME;
         else span = len;
         // long lengths get a partial frame; a later, shorter length ends it
         n = (span > 64) ? $urandom_range(8, 40) : $urandom_range(1, 3 * span + 4);
         set_frame_length(len);
         repeat (n) send_sample(draw_sample());
         phase++;
      end

      push <= 0;
      wait_drained();
      @(negedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
